[hw/rtl/kvs_pkg.sv]
package kvs_pkg;

   localparam int MAX_KEYS_DEF = 16;
   localparam int VAL_W        = 32;
   localparam int FRAC_W       = 16;
   localparam int T_W          = FRAC_W + 1;   // t runs 0 .. 1.0 inclusive
   localparam int COUNT_W      = 5;
   localparam int INDEX_W      = 4;
   localparam int PROD_W       = VAL_W + 1 + T_W + 1;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef struct packed {
      logic                    opcode;
      logic [INDEX_W-1:0]      key_index;
      logic signed [VAL_W-1:0] key_time;
      logic signed [VAL_W-1:0] val_x;
      logic signed [VAL_W-1:0] val_y;
      logic signed [VAL_W-1:0] val_z;
      logic signed [VAL_W-1:0] sample_time;
   } kvs_req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] out_x;
      logic signed [VAL_W-1:0] out_y;
      logic signed [VAL_W-1:0] out_z;
      logic                    held;
   } kvs_rsp_type;

   // one table entry as it sits in the RAM
   typedef struct packed {
      logic signed [VAL_W-1:0] key_time;
      logic signed [VAL_W-1:0] val_x;
      logic signed [VAL_W-1:0] val_y;
      logic signed [VAL_W-1:0] val_z;
   } kvs_entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } kvs_div_status_type;

endpackage

[hw/rtl/keyframe_vector_sampler_unit.sv]
// Load transaction: no result. A sample either holds an end value or interpolates
// within a segment (key scan one entry a cycle from the table RAM, 17-step serial
// divide for t, then three multiply-adds on one shared multiplier). One sample in
// flight; req_stall stays high until its result is in the output register.
// Synchronous reset sets key_count to 1 and empties the output register; the key
// table is not cleared.
module keyframe_vector_sampler_unit #(
   parameter int MAX_KEYS = kvs_pkg::MAX_KEYS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  kvs_pkg::kvs_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output kvs_pkg::kvs_rsp_type          rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [kvs_pkg::COUNT_W-1:0]   csr_data
);

   localparam int AW = $clog2(MAX_KEYS);
   localparam int VW = kvs_pkg::VAL_W;
   localparam int TW = kvs_pkg::T_W;
   localparam int PW = kvs_pkg::PROD_W;
   localparam int EW = $bits(kvs_pkg::kvs_entry_type);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FIRST = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_DIFF  = 3'd4;
   localparam logic [2:0] ST_MUL   = 3'd5;
   localparam logic [2:0] ST_ADD   = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   localparam logic [1:0] SEL_X = 2'd0;
   localparam logic [1:0] SEL_Y = 2'd1;
   localparam logic [1:0] SEL_Z = 2'd2;

   logic [2:0]                 state_ff, state_in;
   logic [kvs_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [AW-1:0]              addr_ff,  addr_in;
   logic [AW-1:0]              last_ff,  last_in;
   logic signed [VW-1:0]       s_ff,     s_in;
   kvs_pkg::kvs_entry_type     prev_ff,  prev_in;
   kvs_pkg::kvs_entry_type     cur_ff,   cur_in;
   logic [TW-1:0]              t_ff,     t_in;
   logic [1:0]                 sel_ff,   sel_in;
   logic signed [VW:0]         d_ff,     d_in;
   logic signed [PW-1:0]       prod_ff,  prod_in;
   logic [VW-1:0]              res_x_ff, res_x_in;
   logic [VW-1:0]              res_y_ff, res_y_in;
   logic [VW-1:0]              res_z_ff, res_z_in;
   logic                       held_ff,  held_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   kvs_pkg::kvs_rsp_type       rsp_data_ff,  rsp_data_in;

   logic                       req_take;
   logic                       ram_wr_en;
   logic [EW-1:0]              ram_rd_data;
   kvs_pkg::kvs_entry_type     ent;
   kvs_pkg::kvs_entry_type     wr_ent;

   logic                       div_start;
   logic [VW-1:0]              div_dividend;
   logic [VW-1:0]              div_divisor;
   kvs_pkg::kvs_div_status_type div_status;
   logic [TW-1:0]              div_quotient;

   logic signed [VW:0]         span;
   logic signed [VW:0]         offset;
   logic                       hit;
   logic signed [VW-1:0]       comp_a;
   logic signed [VW-1:0]       comp_b;
   logic [VW-1:0]              comp_sum;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign wr_ent.key_time = req_data.key_time;
   assign wr_ent.val_x    = req_data.val_x;
   assign wr_ent.val_y    = req_data.val_y;
   assign wr_ent.val_z    = req_data.val_z;
   assign ram_wr_en = req_take && (req_data.opcode == kvs_pkg::OP_LOAD)
                      && (32'(req_data.key_index) < MAX_KEYS);
   assign ent = kvs_pkg::kvs_entry_type'(ram_rd_data);

   kvs_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_KEYS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (AW'(req_data.key_index)),
      .wr_data (wr_ent),
      .rd_addr (addr_in),
      .rd_data (ram_rd_data)
   );

   kvs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // segment bracket test and operands for the divider
   always_comb begin
      span         = {ent.key_time[VW-1], ent.key_time}
                     - {prev_ff.key_time[VW-1], prev_ff.key_time};
      offset       = {s_ff[VW-1], s_ff} - {prev_ff.key_time[VW-1], prev_ff.key_time};
      hit          = (prev_ff.key_time <= s_ff) && (s_ff <= ent.key_time);
      div_dividend = offset[VW-1:0];
      div_divisor  = span[VW-1:0];
      div_start    = (state_ff == ST_SCAN) && hit;
   end

   always_comb begin
      case (sel_ff)
         SEL_X: begin
            comp_a = prev_ff.val_x;
            comp_b = cur_ff.val_x;
         end
         SEL_Y: begin
            comp_a = prev_ff.val_y;
            comp_b = cur_ff.val_y;
         end
         default: begin
            comp_a = prev_ff.val_z;
            comp_b = cur_ff.val_z;
         end
      endcase
      // a + floor(d * t / 2^16), kept to 32 bits
      comp_sum = comp_a + prod_ff[VW+kvs_pkg::FRAC_W-1:kvs_pkg::FRAC_W];
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      last_in      = last_ff;
      s_in         = s_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      t_in         = t_ff;
      sel_in       = sel_ff;
      d_in         = d_ff;
      prod_in      = prod_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_z_in     = res_z_ff;
      held_in      = held_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         count_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_data.opcode == kvs_pkg::OP_SAMPLE)) begin
               s_in    = req_data.sample_time;
               addr_in = '0;
               if (count_ff == '0) begin
                  last_in = '0;
               end else if (32'(count_ff) > MAX_KEYS) begin
                  last_in = AW'(MAX_KEYS - 1);
               end else begin
                  last_in = AW'(count_ff - kvs_pkg::COUNT_W'(1));
               end
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if ((last_ff == '0) || (s_ff <= ent.key_time)) begin
               res_x_in = ent.val_x;
               res_y_in = ent.val_y;
               res_z_in = ent.val_z;
               held_in  = 1'b1;
               state_in = ST_OUT;
            end else begin
               prev_in  = ent;
               addr_in  = AW'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               cur_in   = ent;
               state_in = ST_DIV;
            end else if (addr_ff == last_ff) begin
               // past the last key
               res_x_in = ent.val_x;
               res_y_in = ent.val_y;
               res_z_in = ent.val_z;
               held_in  = 1'b1;
               state_in = ST_OUT;
            end else begin
               prev_in = ent;
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               t_in     = div_quotient;
               sel_in   = SEL_X;
               held_in  = 1'b0;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            d_in     = {comp_b[VW-1], comp_b} - {comp_a[VW-1], comp_a};
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PW'(d_ff * $signed({1'b0, t_ff}));
            state_in = ST_ADD;
         end
         ST_ADD: begin
            case (sel_ff)
               SEL_X:   res_x_in = comp_sum;
               SEL_Y:   res_y_in = comp_sum;
               default: res_z_in = comp_sum;
            endcase
            if (sel_ff == SEL_Z) begin
               state_in = ST_OUT;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = ST_DIFF;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.out_x = res_x_ff;
               rsp_data_in.out_y = res_y_ff;
               rsp_data_in.out_z = res_z_ff;
               rsp_data_in.held  = held_ff;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= kvs_pkg::COUNT_W'(1);
         rsp_valid_ff <= 1'b0;
         addr_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         addr_ff      <= addr_in;
      end
      last_ff     <= last_in;
      s_ff        <= s_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      t_ff        <= t_in;
      sel_ff      <= sel_in;
      d_ff        <= d_in;
      prod_ff     <= prod_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_z_ff    <= res_z_in;
      held_ff     <= held_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/kvs_ram.sv]
module kvs_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/kvs_div.sv]
// Restoring divider, one quotient bit a cycle. Dividend never exceeds the
// divisor, so the quotient has one integer bit and FRAC_W fraction bits.
module kvs_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [kvs_pkg::VAL_W-1:0]        dividend,
   input  logic [kvs_pkg::VAL_W-1:0]        divisor,
   output kvs_pkg::kvs_div_status_type      status,
   output logic [kvs_pkg::T_W-1:0]          quotient
);

   localparam int VW = kvs_pkg::VAL_W;
   localparam int TW = kvs_pkg::T_W;
   localparam int CW = $clog2(TW + 1);

   logic [VW:0]   rem_ff,  rem_in;
   logic [VW-1:0] den_ff,  den_in;
   logic [TW-1:0] q_ff,    q_in;
   logic [CW-1:0] cnt_ff,  cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [VW+1:0] trial;
   logic          ge;
   logic [VW:0]   kept;

   always_comb begin
      trial   = {1'b0, rem_ff} - {2'b00, den_ff};
      ge      = !trial[VW+1];
      kept    = ge ? trial[VW:0] : rem_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = {1'b0, dividend};
         den_in = divisor;
         q_in   = '0;
         cnt_in = CW'(TW);
         if (divisor == '0) begin
            // zero-length segment: t = 0
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         q_in   = {q_ff[TW-2:0], ge};
         rem_in = {kept[VW-1:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = q_ff;

endmodule

[hw/rtl/kvs_checker.sv]
module kvs_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input kvs_pkg::kvs_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input kvs_pkg::kvs_rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // a sample transaction keeps the block busy
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.opcode == kvs_pkg::OP_SAMPLE) |=> req_stall)
      else $error("input not stalled after sample");

   // a load never makes a result appear
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.opcode == kvs_pkg::OP_LOAD) && !rsp_valid
      |=> !rsp_valid)
      else $error("result after load");

   // results only come out of a busy block
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result while idle");

endmodule

bind keyframe_vector_sampler_unit kvs_checker u_kvs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[tb/sv/keyframe_vector_sampler_unit_tb.sv]
module keyframe_vector_sampler_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NKEYS         = kvs_pkg::MAX_KEYS_DEF;
   localparam int IDX_W         = kvs_pkg::INDEX_W;
   localparam int CNT_W         = kvs_pkg::COUNT_W;
   localparam int ITEM_GOAL     = 580;
   localparam int SETTLE_CYCLES = 60;
   localparam int CYCLE_LIMIT   = 500_000;

   localparam logic signed [31:0] Q_MIN = 32'h8000_0000;
   localparam logic signed [31:0] Q_MAX = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {ROW_LOAD, ROW_SAMPLE, ROW_COUNT} row_kind_type;

   // one line of the directed sequence; a sample row keeps its time in ent.key_time
   typedef struct packed {
      row_kind_type           kind;
      logic [IDX_W-1:0]       idx;
      kvs_pkg::kvs_entry_type ent;
      logic [CNT_W-1:0]       count;
      logic                   typed;
      kvs_pkg::kvs_rsp_type   want;
   } dir_row_type;

   localparam kvs_pkg::kvs_entry_type KEY_A  =
      '{32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_2345};
   localparam kvs_pkg::kvs_entry_type KEY_B  =
      '{32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000};
   localparam kvs_pkg::kvs_entry_type KEY_C  = '{32'h0001_0000, 32'h0, 32'h0, 32'h0};
   localparam kvs_pkg::kvs_entry_type KEY_D  =
      '{32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
   localparam kvs_pkg::kvs_entry_type KEY_D2 =
      '{32'h0002_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF};

   localparam kvs_pkg::kvs_rsp_type NO_PT  = '0;
   localparam kvs_pkg::kvs_rsp_type A_HELD = '{KEY_A.val_x, KEY_A.val_y, KEY_A.val_z, 1'b1};
   localparam kvs_pkg::kvs_rsp_type B_END  = '{KEY_B.val_x, KEY_B.val_y, KEY_B.val_z, 1'b0};
   localparam kvs_pkg::kvs_rsp_type B_HELD = '{KEY_B.val_x, KEY_B.val_y, KEY_B.val_z, 1'b1};
   localparam kvs_pkg::kvs_rsp_type D_END  = '{KEY_D.val_x, KEY_D.val_y, KEY_D.val_z, 1'b0};
   localparam kvs_pkg::kvs_rsp_type D_HELD = '{KEY_D.val_x, KEY_D.val_y, KEY_D.val_z, 1'b1};

   localparam logic [CNT_W-1:0] FIRST_COUNTS [3] = '{5'd16, 5'd31, 5'd1};

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   kvs_pkg::kvs_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   kvs_pkg::kvs_rsp_type rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CNT_W-1:0]     csr_data;

   // predictor state
   logic signed [31:0] key_t [NKEYS];
   logic signed [31:0] key_x [NKEYS];
   logic signed [31:0] key_y [NKEYS];
   logic signed [31:0] key_z [NKEYS];
   logic [CNT_W-1:0]   keys_in_use = 5'd1;

   kvs_pkg::kvs_rsp_type due_points [$];
   kvs_pkg::kvs_rsp_type due;
   dir_row_type          dir_tab [22];

   int  fault_count  = 0;
   int  items_sent   = 0;
   int  loads_sent   = 0;
   int  samples_sent = 0;
   int  points_seen  = 0;
   int  held_seen    = 0;
   int  count_writes = 0;
   int  cycle_count  = 0;
   int  stall_left   = 0;
   bit  send_calm    = 1'b0;
   bit  rsp_calm     = 1'b0;

   keyframe_vector_sampler_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int pause_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int keys_active();
      if (keys_in_use < 1) return 1;
      if (keys_in_use > NKEYS) return NKEYS;
      return keys_in_use;
   endfunction

   function automatic logic signed [31:0] lerp(logic signed [31:0] a, logic signed [31:0] b,
                                               longint f);
      longint d;
      longint acc;
      d   = (longint'(b) - longint'(a)) * f;
      acc = longint'(a) + (d >>> 16);
      return acc[31:0];
   endfunction

   function automatic kvs_pkg::kvs_rsp_type curve_value(logic signed [31:0] when);
      int                   n;
      longint               s, t0, t1, frac;
      kvs_pkg::kvs_rsp_type res;
      n   = keys_active();
      s   = when;
      res = '{key_x[0], key_y[0], key_z[0], 1'b1};
      if (n == 1 || s <= key_t[0]) return res;
      for (int i = 0; i + 1 < n; i++) begin
         t0 = key_t[i];
         t1 = key_t[i+1];
         if (t0 <= s && s <= t1) begin
            frac = (t1 == t0) ? 0 : ((s - t0) <<< 16) / (t1 - t0);
            res.out_x = lerp(key_x[i], key_x[i+1], frac);
            res.out_y = lerp(key_y[i], key_y[i+1], frac);
            res.out_z = lerp(key_z[i], key_z[i+1], frac);
            res.held  = 1'b0;
            return res;
         end
      end
      res = '{key_x[n-1], key_y[n-1], key_z[n-1], 1'b1};
      return res;
   endfunction

   function automatic logic signed [31:0] pick_val();
      case ($urandom_range(0, 15))
         0:       return Q_MAX;
         1:       return Q_MIN;
         2:       return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   // every field random, so fields unused by the opcode carry junk
   function automatic kvs_pkg::kvs_req_type random_req();
      kvs_pkg::kvs_req_type r;
      r.opcode      = 1'($urandom);
      r.key_index   = IDX_W'($urandom);
      r.key_time    = $urandom;
      r.val_x       = $urandom;
      r.val_y       = $urandom;
      r.val_z       = $urandom;
      r.sample_time = $urandom;
      return r;
   endfunction

   task automatic send_item(kvs_pkg::kvs_req_type r, bit typed, kvs_pkg::kvs_rsp_type want);
      int gap;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (r.opcode == kvs_pkg::OP_LOAD) begin
         key_t[r.key_index] = r.key_time;
         key_x[r.key_index] = r.val_x;
         key_y[r.key_index] = r.val_y;
         key_z[r.key_index] = r.val_z;
         loads_sent++;
      end else begin
         due_points.push_back(typed ? want : curve_value(r.sample_time));
         samples_sent++;
      end
      gap = send_calm ? 0 : pause_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (due_points.size() != 0) @(posedge clock);
   endtask

   // loads give no result, so allow the block to finish one before touching the register
   task automatic set_key_count(logic [CNT_W-1:0] v);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      keys_in_use = v;
      count_writes++;
   endtask

   task automatic run_curve_phase(logic [CNT_W-1:0] kc);
      int                   n, style, k, off;
      int                   stamps [$];
      longint               lo, hi, pick;
      longint unsigned      span, r64;
      kvs_pkg::kvs_req_type r;
      logic signed [31:0]   a, b;
      bit                   reverse;

      set_key_count(kc);
      send_calm = ($urandom_range(0, 3) == 0);
      rsp_calm  = ($urandom_range(0, 3) == 0);
      n       = keys_active();
      style   = $urandom_range(0, 3);
      reverse = $urandom_range(0, 1);

      case (style)
         1: begin
            // short steps, some of them zero-length
            lo = int'($urandom) >>> 1;
            for (int j = 0; j < n; j++) begin
               stamps.push_back(int'(lo));
               lo += ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1 << 20);
            end
         end
         3: begin
            for (int j = 0; j < n - 2; j++) stamps.push_back(int'($urandom));
            stamps.sort();
            if (n > 1) begin
               stamps.push_front(int'(Q_MIN));
               stamps.push_back(int'(Q_MAX));
            end else begin
               stamps.push_back(int'($urandom));
            end
         end
         default: begin
            for (int j = 0; j < n; j++) stamps.push_back(int'($urandom));
            // style 2 leaves the times out of order
            if (style == 0) stamps.sort();
         end
      endcase

      for (int j = 0; j < n; j++) begin
         k = reverse ? n - 1 - j : j;
         r = random_req();
         r.opcode    = kvs_pkg::OP_LOAD;
         r.key_index = IDX_W'(k);
         r.key_time  = stamps[k];
         r.val_x     = pick_val();
         r.val_y     = pick_val();
         r.val_z     = pick_val();
         send_item(r, 1'b0, NO_PT);
      end
      for (int j = n; j < NKEYS; j++) begin
         if ($urandom_range(0, 3) == 0) begin
            r = random_req();
            r.opcode = kvs_pkg::OP_LOAD;
            r.key_index = IDX_W'(j);
            send_item(r, 1'b0, NO_PT);
         end
      end

      repeat ($urandom_range(8, 30)) begin
         if ($urandom_range(0, 24) == 0) wait_drained();
         r = random_req();
         if ($urandom_range(0, 11) == 0) begin
            r.opcode = kvs_pkg::OP_LOAD;
            send_item(r, 1'b0, NO_PT);
         end else begin
            r.opcode = kvs_pkg::OP_SAMPLE;
            k = $urandom_range(0, n - 1);
            case ($urandom_range(0, 9))
               0, 1: pick = key_t[k];
               2, 3, 4, 5: begin
                  a  = key_t[k];
                  b  = key_t[(k + 1 < n) ? k + 1 : k];
                  lo = (a < b) ? a : b;
                  hi = (a < b) ? b : a;
                  span = hi - lo + 1;
                  r64  = {$urandom, $urandom};
                  pick = lo + longint'(r64 % span);
               end
               6: begin
                  off  = $urandom_range(0, 1 << 16);
                  pick = longint'(key_t[0]) - off;
               end
               7: begin
                  off  = $urandom_range(0, 1 << 16);
                  pick = longint'(key_t[n-1]) + off;
               end
               8: pick = int'($urandom);
               default: pick = $urandom_range(0, 1) ? Q_MIN : Q_MAX;
            endcase
            if (pick < Q_MIN) pick = Q_MIN;
            if (pick > Q_MAX) pick = Q_MAX;
            r.sample_time = pick[31:0];
            send_item(r, 1'b0, NO_PT);
         end
      end
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (!rsp_calm) stall_left <= pause_len();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_points.size() == 0) begin
            $error("result transaction with nothing expected: %h", rsp_data);
            fault_count++;
         end else begin
            due = due_points.pop_front();
            points_seen++;
            if (rsp_data.held) held_seen++;
            if (rsp_data.out_x !== due.out_x) begin
               $error("out_x: expected %h, got %h", due.out_x, rsp_data.out_x);
               fault_count++;
            end
            if (rsp_data.out_y !== due.out_y) begin
               $error("out_y: expected %h, got %h", due.out_y, rsp_data.out_y);
               fault_count++;
            end
            if (rsp_data.out_z !== due.out_z) begin
               $error("out_z: expected %h, got %h", due.out_z, rsp_data.out_z);
               fault_count++;
            end
            if (rsp_data.held !== due.held) begin
               $error("held: expected %b, got %b", due.held, rsp_data.held);
               fault_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("keyframe_vector_sampler_unit_tb: done, errors");
         $finish;
      end
   end

   initial begin
      kvs_pkg::kvs_req_type r;
      logic [CNT_W-1:0]     kc;
      int                   phase;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_data  = '0;
      foreach (key_t[i]) begin
         key_t[i] = '0;
         key_x[i] = '0;
         key_y[i] = '0;
         key_z[i] = '0;
      end

      // entries B and C share a time, giving a zero-length segment
      dir_tab = '{
         '{ROW_LOAD,   4'd0, KEY_A, 5'd0, 1'b0, NO_PT},
         '{ROW_SAMPLE, 4'd0, '{32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0}, 5'd0, 1'b1, A_HELD},
         '{ROW_SAMPLE, 4'd0, '{32'h8000_0000, 32'h0, 32'h0, 32'h0}, 5'd0, 1'b1, A_HELD},
         '{ROW_LOAD,   4'd1, KEY_B, 5'd0, 1'b0, NO_PT},
         '{ROW_LOAD,   4'd2, KEY_C, 5'd0, 1'b0, NO_PT},
         '{ROW_LOAD,   4'd3, KEY_D, 5'd0, 1'b0, NO_PT},
         '{ROW_COUNT,  4'd0, '0,    5'd0, 1'b0, NO_PT},
         '{ROW_SAMPLE, 4'd0, '{32'h0005_0000, 32'h0, 32'h0, 32'h0}, 5'd0, 1'b1, A_HELD},
         '{ROW_COUNT,  4'd0, '0,    5'd4, 1'b0, NO_PT},
         '{ROW_SAMPLE, 4'd0, '{32'hFFFF_0000, 32'h0, 32'h0, 32'h0}, 5'd0, 1'b1, A_HELD},
         '{ROW_SAMPLE, 4'd0, '{32'h8000_0000, 32'h0, 32'h0, 32'h0}, 5'd0, 1'b1, A_HELD},
         '{ROW_SAMPLE, 4'd0, '{32'h0000_0000, 32'h0, 32'h0, 32'h0}, 5'd0, 1'b0, NO_PT},
         '{ROW_SAMPLE, 4'd0, '{32'h0001_0000, 32'h0, 32'h0, 32'h0}, 5'd0, 1'b1, B_END},
         '{ROW_SAMPLE, 4'd0, '{32'h0001_0001, 32'h0, 32'h0, 32'h0}, 5'd0, 1'b0, NO_PT},
         '{ROW_SAMPLE, 4'd0, '{32'h7FFF_FFFE, 32'h0, 32'h0, 32'h0}, 5'd0, 1'b0, NO_PT},
         '{ROW_SAMPLE, 4'd0, '{32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0}, 5'd0, 1'b1, D_END},
         '{ROW_LOAD,   4'd3, KEY_D2, 5'd0, 1'b0, NO_PT},
         '{ROW_SAMPLE, 4'd0, '{32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0}, 5'd0, 1'b1, D_HELD},
         '{ROW_SAMPLE, 4'd0, '{32'h0001_8000, 32'h0, 32'h0, 32'h0}, 5'd0, 1'b0, NO_PT},
         '{ROW_COUNT,  4'd0, '0,    5'd2, 1'b0, NO_PT},
         '{ROW_SAMPLE, 4'd0, '{32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0}, 5'd0, 1'b1, B_HELD},
         '{ROW_SAMPLE, 4'd0, '{32'hFFFF_8000, 32'h0, 32'h0, 32'h0}, 5'd0, 1'b0, NO_PT}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_COUNT) begin
            set_key_count(dir_tab[i].count);
         end else begin
            r = random_req();
            if (dir_tab[i].kind == ROW_LOAD) begin
               r.opcode    = kvs_pkg::OP_LOAD;
               r.key_index = dir_tab[i].idx;
               r.key_time  = dir_tab[i].ent.key_time;
               r.val_x     = dir_tab[i].ent.val_x;
               r.val_y     = dir_tab[i].ent.val_y;
               r.val_z     = dir_tab[i].ent.val_z;
            end else begin
               r.opcode      = kvs_pkg::OP_SAMPLE;
               r.sample_time = dir_tab[i].ent.key_time;
            end
            send_item(r, dir_tab[i].typed, dir_tab[i].want);
         end
      end

      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         if (phase < 3) begin
            kc = FIRST_COUNTS[phase];
         end else begin
            case ($urandom_range(0, 7))
               0:       kc = 5'd0;
               1:       kc = 5'd1;
               2:       kc = 5'd16;
               3:       kc = CNT_W'($urandom_range(17, 31));
               default: kc = CNT_W'($urandom_range(2, 15));
            endcase
         end
         run_curve_phase(kc);
         phase++;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d transactions (%0d loads, %0d samples) over %0d key_count settings",
               items_sent, loads_sent, samples_sent, count_writes);
      $display("%0d results checked: %0d end values held, %0d interpolated",
               points_seen, held_seen, points_seen - held_seen);
      if (fault_count == 0) begin
         $display("keyframe_vector_sampler_unit_tb: done, clean");
      end else begin
         $display("keyframe_vector_sampler_unit_tb: done, errors");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/kvs_pkg.sv
hw/rtl/kvs_ram.sv
hw/rtl/kvs_div.sv
hw/rtl/keyframe_vector_sampler_unit.sv
hw/rtl/kvs_checker.sv
tb/sv/keyframe_vector_sampler_unit_tb.sv
